// ===== hw/rtl/bba_pkg.sv =====
// Shared types, sizes and tree-layout constants for the buddy allocator.
// No dependencies; bba_dp, bba_ctrl and the core import this package.
`timescale 1ns / 1ps
`default_nettype none
package bba_pkg;

	localparam int LEVELS         = 11;
	localparam int MIN_BLOCK_LOG2 = 10;
	localparam int HEADER_BYTES   = 4;
	localparam int TOP_LEVEL      = LEVELS - 1;
	localparam int LEAF_W         = LEVELS - 1;
	localparam int LEAVES         = 1 << LEAF_W;
	localparam int LVL_W          = 4;
	localparam int CNT_W          = LEVELS;
	localparam int WORD_LOG2      = 5;
	localparam int WORD_W         = 1 << WORD_LOG2;
	localparam int WPTR_W         = LEAF_W - WORD_LOG2;
	localparam int SIZE_W         = 21;
	localparam int OFF_W          = 20;
	localparam int NEED_W         = SIZE_W + 1;
	localparam int STAT_W         = 2;

	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NO_SPACE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_BAD_FREE = 2'd2;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	// free-mark words used by one level of the tree
	function automatic int level_words(input int l);
		return ((LEAVES >> l) + WORD_W - 1) >> WORD_LOG2;
	endfunction

	function automatic int total_words();
		int s;
		s = 0;
		for (int i = 0; i < LEVELS; i++) begin
			s = s + level_words(i);
		end
		return s;
	endfunction

	localparam int FWORDS  = total_words();
	localparam int FADDR_W = $clog2(FWORDS);

	typedef logic [FADDR_W-1:0] base_tab_t [1 << LVL_W];

	function automatic base_tab_t make_base();
		base_tab_t t;
		int s;
		s = 0;
		for (int i = 0; i < (1 << LVL_W); i++) begin
			t[i] = FADDR_W'(s);
			if (i < LEVELS) begin
				s = s + level_words(i);
			end
		end
		return t;
	endfunction

	localparam base_tab_t LVL_BASE = make_base();

	// word of the free-mark memory that holds node (lvl, pos)
	function automatic logic [FADDR_W-1:0] word_addr(input logic [LVL_W-1:0] lvl,
		input logic [LEAF_W-1:0] pos);
		return LVL_BASE[lvl] + FADDR_W'(pos >> WORD_LOG2);
	endfunction

	typedef struct packed {
		logic              kind;
		logic [SIZE_W-1:0] request_size;
		logic [OFF_W-1:0]  free_offset;
	} item_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [OFF_W-1:0]  block_offset;
		logic [LVL_W-1:0]  block_level;
	} result_t;

	typedef struct packed {
		logic clr;
		logic load;
		logic pick;
		logic a_rd;
		logic a_chk;
		logic s_rd;
		logic s_wr;
		logic a_fin;
		logic f_rd;
		logic f_chk;
		logic m_rd;
		logic m_chk;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic in_kind;
		logic pick_fail;
		logic hit;
		logic split_more;
		logic bad_off;
		logic bad_mark;
		logic merge_more;
	} dp_sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bba_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module bba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule
`default_nettype wire

// ===== hw/rtl/bba_dp.sv =====
// Datapath: item and result registers, per-level free counts, free-mark and
// allocation memories. Depends on bba_pkg and bba_ram.
`timescale 1ns / 1ps
`default_nettype none
module bba_dp
	import bba_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire item_t   item,
	input  wire dp_cmd_t cmd,
	output dp_sts_t      sts,
	output result_t      result
);

	item_t               item_q;
	result_t             res_q;
	logic [LVL_W-1:0]    want_q;
	logic [LVL_W-1:0]    lvl_q;
	logic [LEAF_W-1:0]   pos_q;
	logic [WPTR_W-1:0]   wptr_q;
	logic [FADDR_W-1:0]  rd_addr_q;
	logic [LEAF_W-1:0]   clr_q;
	logic [CNT_W-1:0]    cnt_q [LEVELS];

	logic                f_we;
	logic [FADDR_W-1:0]  f_addr;
	logic [WORD_W-1:0]   f_wdata;
	logic [WORD_W-1:0]   f_rdata;
	logic                a_we;
	logic [LEAF_W-1:0]   a_addr;
	logic [LVL_W:0]      a_wdata;
	logic [LVL_W:0]      a_rdata;

	logic [NEED_W-1:0]   need;
	logic [LVL_W-1:0]    want_c;
	logic                too_big;
	logic [LVL_W-1:0]    pick_c;
	logic                found;
	logic [WORD_LOG2-1:0] low_bit;
	logic [WORD_LOG2-1:0] bud_bit;
	logic [LEAF_W-1:0]   leaf;
	logic [LVL_W-1:0]    lvl_c;
	logic                cnt_inc;
	logic                cnt_dec;
	logic                merge_more;

	// size class and lowest level at or above it with a free block
	always_comb begin
		need    = NEED_W'(item_q.request_size) + NEED_W'(HEADER_BYTES);
		want_c  = '0;
		too_big = 1'b1;
		for (int w = LEVELS - 1; w >= 0; w--) begin
			if (need <= (NEED_W'(1) << (MIN_BLOCK_LOG2 + w))) begin
				want_c  = LVL_W'(w);
				too_big = 1'b0;
			end
		end
		pick_c = '0;
		found  = 1'b0;
		for (int k = LEVELS - 1; k >= 0; k--) begin
			if (LVL_W'(k) >= want_c && cnt_q[k] != '0) begin
				pick_c = LVL_W'(k);
				found  = 1'b1;
			end
		end
	end

	always_comb begin
		low_bit = '0;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			if (f_rdata[b]) begin
				low_bit = WORD_LOG2'(b);
			end
		end
	end

	assign leaf       = item_q.free_offset[OFF_W-1:MIN_BLOCK_LOG2];
	assign lvl_c      = (a_rdata[LVL_W-1:0] > LVL_W'(TOP_LEVEL)) ?
		LVL_W'(TOP_LEVEL) : a_rdata[LVL_W-1:0];
	assign bud_bit    = pos_q[WORD_LOG2-1:0] ^ WORD_LOG2'(1);
	assign merge_more = (lvl_q != LVL_W'(TOP_LEVEL)) && f_rdata[bud_bit];

	// free-mark memory port
	always_comb begin
		f_we    = 1'b0;
		f_addr  = rd_addr_q;
		f_wdata = f_rdata;
		if (cmd.clr) begin
			f_we    = (clr_q < LEAF_W'(FWORDS));
			f_addr  = clr_q[FADDR_W-1:0];
			f_wdata = (clr_q[FADDR_W-1:0] == LVL_BASE[TOP_LEVEL]) ? WORD_W'(1) : '0;
		end else if (cmd.a_rd) begin
			f_addr = word_addr(lvl_q, {wptr_q, WORD_LOG2'(0)});
		end else if (cmd.a_chk) begin
			f_we    = (f_rdata != '0);
			f_wdata = f_rdata & ~(WORD_W'(1) << low_bit);
		end else if (cmd.s_rd) begin
			f_addr = word_addr(lvl_q - LVL_W'(1), {pos_q[LEAF_W-2:0], 1'b1});
		end else if (cmd.s_wr) begin
			f_we    = 1'b1;
			f_wdata = f_rdata | (WORD_W'(1) << {pos_q[WORD_LOG2-1:1], 1'b1});
		end else if (cmd.m_rd) begin
			f_addr = word_addr(lvl_q, pos_q);
		end else if (cmd.m_chk) begin
			f_we    = 1'b1;
			f_wdata = merge_more ? (f_rdata & ~(WORD_W'(1) << bud_bit)) :
				(f_rdata | (WORD_W'(1) << pos_q[WORD_LOG2-1:0]));
		end
	end

	// allocation memory port: {mark, level} per minimum block
	always_comb begin
		a_we    = 1'b0;
		a_addr  = leaf;
		a_wdata = {1'b0, a_rdata[LVL_W-1:0]};
		if (cmd.clr) begin
			a_we    = 1'b1;
			a_addr  = clr_q;
			a_wdata = '0;
		end else if (cmd.f_chk) begin
			a_we = a_rdata[LVL_W];
		end else if (cmd.a_fin) begin
			a_we    = 1'b1;
			a_addr  = pos_q << want_q;
			a_wdata = {1'b1, want_q};
		end
	end

	bba_ram #(.WIDTH(WORD_W), .DEPTH(FWORDS)) u_free_mem (
		.clk   (clk),
		.we    (f_we),
		.addr  (f_addr),
		.wdata (f_wdata),
		.rdata (f_rdata)
	);

	bba_ram #(.WIDTH(LVL_W + 1), .DEPTH(LEAVES)) u_alloc_mem (
		.clk   (clk),
		.we    (a_we),
		.addr  (a_addr),
		.wdata (a_wdata),
		.rdata (a_rdata)
	);

	assign cnt_dec = (cmd.a_chk && f_rdata != '0) || (cmd.m_chk && merge_more);
	assign cnt_inc = cmd.s_wr || (cmd.m_chk && !merge_more);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			for (int i = 0; i < LEVELS; i++) begin
				cnt_q[i] <= (i == TOP_LEVEL) ? CNT_W'(1) : '0;
			end
		end else begin
			if (cmd.clr) begin
				clr_q <= clr_q + LEAF_W'(1);
			end
			for (int i = 0; i < LEVELS; i++) begin
				if (lvl_q == LVL_W'(i)) begin
					if (cnt_inc) begin
						cnt_q[i] <= cnt_q[i] + CNT_W'(1);
					end else if (cnt_dec) begin
						cnt_q[i] <= cnt_q[i] - CNT_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (cmd.a_rd || cmd.s_rd || cmd.m_rd) begin
			rd_addr_q <= f_addr;
		end
		if (cmd.pick) begin
			want_q <= want_c;
			lvl_q  <= pick_c;
			wptr_q <= '0;
			if (too_big || !found) begin
				res_q <= '{status: STAT_NO_SPACE, block_offset: '0, block_level: '0};
			end
		end
		if (cmd.a_chk) begin
			if (f_rdata != '0) begin
				pos_q <= {wptr_q, low_bit};
			end else begin
				wptr_q <= wptr_q + WPTR_W'(1);
			end
		end
		if (cmd.s_rd) begin
			lvl_q <= lvl_q - LVL_W'(1);
			pos_q <= {pos_q[LEAF_W-2:0], 1'b0};
		end
		if (cmd.a_fin) begin
			res_q <= '{status: STAT_OK,
				block_offset: {LEAF_W'(pos_q << want_q), MIN_BLOCK_LOG2'(0)},
				block_level: want_q};
		end
		if (cmd.f_rd && item_q.free_offset[MIN_BLOCK_LOG2-1:0] != '0) begin
			res_q <= '{status: STAT_BAD_FREE, block_offset: item_q.free_offset,
				block_level: '0};
		end
		if (cmd.f_chk) begin
			if (!a_rdata[LVL_W]) begin
				res_q <= '{status: STAT_BAD_FREE, block_offset: item_q.free_offset,
					block_level: '0};
			end else begin
				lvl_q <= lvl_c;
				pos_q <= leaf >> lvl_c;
				res_q <= '{status: STAT_OK, block_offset: item_q.free_offset,
					block_level: lvl_c};
			end
		end
		if (cmd.m_chk && merge_more) begin
			lvl_q <= lvl_q + LVL_W'(1);
			pos_q <= pos_q >> 1;
		end
	end

	assign sts.clr_done   = (clr_q == '1);
	assign sts.in_kind    = item.kind;
	assign sts.pick_fail  = too_big || !found;
	assign sts.hit        = (f_rdata != '0);
	assign sts.split_more = (lvl_q > want_q);
	assign sts.bad_off    = (item_q.free_offset[MIN_BLOCK_LOG2-1:0] != '0);
	assign sts.bad_mark   = !a_rdata[LVL_W];
	assign sts.merge_more = merge_more;
	assign result         = res_q;

endmodule
`default_nettype wire

// ===== hw/rtl/bba_ctrl.sv =====
// Controller state machine: sequences clear, search, split, free and merge steps.
// Depends on bba_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bba_ctrl
	import bba_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd,
	output logic         busy,
	output logic         done
);

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_PICK  = 4'd2;
	localparam logic [3:0] S_ARD   = 4'd3;
	localparam logic [3:0] S_ACHK  = 4'd4;
	localparam logic [3:0] S_SRD   = 4'd5;
	localparam logic [3:0] S_SWR   = 4'd6;
	localparam logic [3:0] S_AFIN  = 4'd7;
	localparam logic [3:0] S_FRD   = 4'd8;
	localparam logic [3:0] S_FCHK  = 4'd9;
	localparam logic [3:0] S_MRD   = 4'd10;
	localparam logic [3:0] S_MCHK  = 4'd11;
	localparam logic [3:0] S_DONE  = 4'd12;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = (sts.in_kind == KIND_FREE) ? S_FRD : S_PICK;
				end
			end
			S_PICK: begin
				cmd.pick = 1'b1;
				state_d  = sts.pick_fail ? S_DONE : S_ARD;
			end
			S_ARD: begin
				cmd.a_rd = 1'b1;
				state_d  = S_ACHK;
			end
			S_ACHK: begin
				cmd.a_chk = 1'b1;
				if (!sts.hit) state_d = S_ARD;
				else          state_d = sts.split_more ? S_SRD : S_AFIN;
			end
			S_SRD: begin
				cmd.s_rd = 1'b1;
				state_d  = S_SWR;
			end
			S_SWR: begin
				cmd.s_wr = 1'b1;
				state_d  = sts.split_more ? S_SRD : S_AFIN;
			end
			S_AFIN: begin
				cmd.a_fin = 1'b1;
				state_d   = S_DONE;
			end
			S_FRD: begin
				cmd.f_rd = 1'b1;
				state_d  = sts.bad_off ? S_DONE : S_FCHK;
			end
			S_FCHK: begin
				cmd.f_chk = 1'b1;
				state_d   = sts.bad_mark ? S_DONE : S_MRD;
			end
			S_MRD: begin
				cmd.m_rd = 1'b1;
				state_d  = S_MCHK;
			end
			S_MCHK: begin
				cmd.m_chk = 1'b1;
				state_d   = sts.merge_more ? S_MRD : S_DONE;
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

endmodule
`default_nettype wire

// ===== hw/rtl/buddy_block_allocator_core.sv =====
// Buddy allocator core: 1 MB region, 11 levels from 1 KB to 1 MB; one item at a time.
// Allocate: without space it reports no space, else it scans free-mark words (1 to 32) and splits.
// Free: rejected for a bad offset or an unmarked block, else it merges; steps share the single free-mark port.
// Result strobes done for one cycle; the receiver cannot stall it.
// After reset busy stays high while both memories are cleared.
// Depends on bba_pkg, bba_ctrl, bba_dp.
`timescale 1ns / 1ps
`default_nettype none
module buddy_block_allocator_core
	import bba_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	input  wire item_t item,
	output logic       busy,
	output logic       done,
	output result_t    result
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	bba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	bba_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts),
		.result (result)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transfer did not raise busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("result strobe longer than one cycle");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == STAT_OK |-> result.block_level <= LVL_W'(TOP_LEVEL))
		else $error("result level beyond top level");

endmodule
`default_nettype wire
